// File: hdl/iexu_pkg.sv
// ----------------------------------------------------------------------------
// iexu_pkg: shared definitions of the integer execute unit
// Opcode, state and multiply/divide codes, flag positions and defaults.
// ----------------------------------------------------------------------------
package iexu_pkg;

   localparam int DATA_WIDTH_DEF = 64;
   localparam int NUM_REGS_DEF   = 8;

   localparam logic [5:0]  SHIFT_MASK = 6'd63;
   localparam logic [63:0] MASK_8     = 64'hFF;
   localparam logic [63:0] MASK_16    = 64'hFFFF;
   localparam logic [63:0] MASK_32    = 64'hFFFF_FFFF;
   localparam logic [2:0]  IDX_MASK   = 3'd7;

   // Flag bit positions.
   localparam int FLAG_Z  = 0;
   localparam int FLAG_SL = 1;
   localparam int FLAG_UL = 2;
   localparam int FLAG_OV = 3;

   typedef enum logic [4:0] {
      CMD_MOV    = 5'd0,
      CMD_MOVIMM = 5'd1,
      CMD_ADD    = 5'd2,
      CMD_SUB    = 5'd3,
      CMD_MUL    = 5'd4,
      CMD_SMUL   = 5'd5,
      CMD_UDIV   = 5'd6,
      CMD_SDIV   = 5'd7,
      CMD_UMOD   = 5'd8,
      CMD_NEG    = 5'd9,
      CMD_AND    = 5'd10,
      CMD_OR     = 5'd11,
      CMD_XOR    = 5'd12,
      CMD_NOT    = 5'd13,
      CMD_SHL    = 5'd14,
      CMD_SHR    = 5'd15,
      CMD_SAR    = 5'd16,
      CMD_CMP    = 5'd17,
      CMD_TEST   = 5'd18,
      CMD_JMP    = 5'd19,
      CMD_JE     = 5'd20,
      CMD_JNE    = 5'd21,
      CMD_JL     = 5'd22,
      CMD_JLE    = 5'd23,
      CMD_JG     = 5'd24,
      CMD_JGE    = 5'd25,
      CMD_LEA    = 5'd26,
      CMD_TRUNC8 = 5'd27,
      CMD_TRUNC16 = 5'd28,
      CMD_TRUNC32 = 5'd29
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_MDWAIT = 2'd2,
      ST_COMMIT = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      MD_MUL  = 2'd0,
      MD_UDIV = 2'd1,
      MD_SDIV = 2'd2,
      MD_UMOD = 2'd3
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_ctrl_type;

endpackage

// File: hdl/iexu_req_if.sv
// ----------------------------------------------------------------------------
// iexu_req_if: instruction channel
// Carries one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface iexu_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cmd;
   logic [2:0]  dst_reg;
   logic [2:0]  src_reg;
   logic [63:0] immediate;

   modport source (output valid, cmd, dst_reg, src_reg, immediate, input ready);
   modport sink   (input valid, cmd, dst_reg, src_reg, immediate, output ready);
endinterface

// File: hdl/iexu_rsp_if.sv
// ----------------------------------------------------------------------------
// iexu_rsp_if: result channel
// Carries the outcome of one instruction per transfer.
// ----------------------------------------------------------------------------
interface iexu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_value;
   logic        reg_written;
   logic [3:0]  flags_now;
   logic        branch_taken;
   logic [63:0] branch_target;
   logic        div_error;

   modport source (output valid, result_value, reg_written, flags_now, branch_taken,
                   branch_target, div_error, input ready);
   modport sink   (input valid, result_value, reg_written, flags_now, branch_taken,
                   branch_target, div_error, output ready);
endinterface

// File: hdl/iexu_regfile.sv
// ----------------------------------------------------------------------------
// iexu_regfile: general register file
// One write port, two registered read ports; unwritten entries read zero.
// ----------------------------------------------------------------------------
module iexu_regfile #(
   parameter int NUM_REGS   = iexu_pkg::NUM_REGS_DEF,
   parameter int DATA_WIDTH = iexu_pkg::DATA_WIDTH_DEF,
   parameter int AW         = $clog2(NUM_REGS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output logic [DATA_WIDTH-1:0] rd_data_a,
   output logic [DATA_WIDTH-1:0] rd_data_b,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data
);

   logic [DATA_WIDTH-1:0] mem [NUM_REGS];
   logic [NUM_REGS-1:0]   valid_ff;
   logic [DATA_WIDTH-1:0] data_a_ff, data_b_ff;
   logic                  va_ff, vb_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= mem[rd_addr_a];
         data_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            va_ff <= valid_ff[rd_addr_a];
            vb_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = va_ff ? data_a_ff : '0;
   assign rd_data_b = vb_ff ? data_b_ff : '0;

endmodule

// File: hdl/iexu_muldiv.sv
// ----------------------------------------------------------------------------
// iexu_muldiv: iterative multiply and divide unit
// One shared adder does shift-add multiply or restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module iexu_muldiv #(
   parameter int DATA_WIDTH = iexu_pkg::DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  iexu_pkg::md_ctrl_type  ctrl,
   input  logic [DATA_WIDTH-1:0]  op_a,
   input  logic [DATA_WIDTH-1:0]  op_b,
   output logic                   done,
   output logic [DATA_WIDTH-1:0]  result
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  x_ff, x_in;     // multiplier / quotient
   logic [W-1:0]  y_ff, y_in;     // multiplicand / divisor
   logic [W:0]    acc_ff, acc_in; // product / remainder
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   iexu_pkg::md_op_type op_ff, op_in;

   logic          is_mul;
   logic [W:0]    shifted, add_a, add_b, sum;
   logic [W-1:0]  abs_a, abs_b;

   assign is_mul  = (op_ff == iexu_pkg::MD_MUL);
   assign shifted = {acc_ff[W-1:0], x_ff[W-1]};
   assign add_a   = is_mul ? {1'b0, acc_ff[W-1:0]} : shifted;
   assign add_b   = is_mul ? {1'b0, (x_ff[0] ? y_ff : '0)} : ~{1'b0, y_ff};
   // The carry-in turns the inverted divisor into a subtraction.
   assign sum     = add_a + add_b + {{W{1'b0}}, !is_mul};

   assign abs_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
   assign abs_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;

   assign done = busy_ff && (cnt_ff == '0);

   always_comb begin
      case (op_ff)
         iexu_pkg::MD_MUL:  result = acc_ff[W-1:0];
         iexu_pkg::MD_UDIV: result = x_ff;
         iexu_pkg::MD_SDIV: result = neg_ff ? (~x_ff + 1'b1) : x_ff;
         iexu_pkg::MD_UMOD: result = acc_ff[W-1:0];
         default:           result = x_ff;
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      op_in   = op_ff;
      if (ctrl.start) begin
         op_in   = ctrl.op;
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         acc_in  = '0;
         neg_in  = op_a[W-1] ^ op_b[W-1];
         if (ctrl.op == iexu_pkg::MD_SDIV) begin
            x_in = abs_a;
            y_in = abs_b;
         end else begin
            x_in = op_a;
            y_in = op_b;
         end
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (is_mul) begin
               acc_in = {1'b0, sum[W-1:0]};
               y_in   = {y_ff[W-2:0], 1'b0};
               x_in   = {1'b0, x_ff[W-1:1]};
            end else if (!sum[W]) begin
               acc_in = sum;
               x_in   = {x_ff[W-2:0], 1'b1};
            end else begin
               acc_in = shifted;
               x_in   = {x_ff[W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// File: hdl/integer_execute_unit_with_flags.sv
// ----------------------------------------------------------------------------
// integer_execute_unit_with_flags: integer execute unit with condition flags
// Executes one decoded instruction at a time against a register file and flags.
// ----------------------------------------------------------------------------
// An instruction is taken in the idle state, its registers are read in that
// transfer cycle and it executes in the next; a simple one enters commit in
// the one after and waits there until the result register is free. Multiply,
// signed multiply, divide, signed divide and modulo run through one
// shift-add/subtract unit at one bit a cycle and commit once it is done. A
// divide by zero reports div_error without starting that unit. The register
// file reads zero until an entry is first written; no clearing pass is needed.
module integer_execute_unit_with_flags #(
   parameter int NUM_REGS   = iexu_pkg::NUM_REGS_DEF,
   parameter int DATA_WIDTH = iexu_pkg::DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   iexu_req_if.sink     req_if,
   iexu_rsp_if.source   rsp_if,
   input  logic         csr_we,
   input  logic [63:0]  csr_wdata
);

   localparam int W  = DATA_WIDTH;
   localparam int AW = $clog2(NUM_REGS);

   iexu_pkg::state_type state_ff, state_in;

   // Latched instruction.
   iexu_pkg::cmd_type cmd_ff;
   logic [2:0]        dst_ff, src_ff;
   logic [63:0]       imm_ff;
   logic [63:0]       code_base_ff;

   // Pending outcome.
   logic [W-1:0] res_ff;
   logic         wr_ff, taken_ff, derr_ff;
   logic [63:0]  target_ff;
   logic [3:0]   flags_ff, flags_pend_ff;

   // Response registers.
   logic         rsp_valid_ff;
   logic [63:0]  rsp_result_ff, rsp_target_ff;
   logic         rsp_wr_ff, rsp_taken_ff, rsp_derr_ff;
   logic [3:0]   rsp_flags_ff;

   logic accept, commit, start_md, md_done;
   iexu_pkg::md_ctrl_type md_ctrl;
   logic [W-1:0] md_result;

   logic [4:0]   src_wide, dst_wide, rq_src_wide, rq_dst_wide;
   logic         src_ok, dst_ok;
   logic [W-1:0] rf_a, rf_b, a, b;

   // ------------------------------------------------------------------ control
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iexu_pkg::ST_IDLE:   if (req_if.valid) state_in = iexu_pkg::ST_EXEC;
         iexu_pkg::ST_EXEC:   state_in = start_md ? iexu_pkg::ST_MDWAIT
                                                  : iexu_pkg::ST_COMMIT;
         iexu_pkg::ST_MDWAIT: if (md_done) state_in = iexu_pkg::ST_COMMIT;
         iexu_pkg::ST_COMMIT: if (!rsp_valid_ff || rsp_if.ready) begin
            state_in = iexu_pkg::ST_IDLE;
         end
         default:             state_in = iexu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      commit       = 1'b0;
      case (state_ff)
         iexu_pkg::ST_IDLE:   req_if.ready = 1'b1;
         iexu_pkg::ST_COMMIT: commit = !rsp_valid_ff || rsp_if.ready;
         default: begin
            req_if.ready = 1'b0;
            commit       = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iexu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff <= '0;
      end else if (csr_we) begin
         code_base_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= iexu_pkg::cmd_type'(req_if.cmd);
         dst_ff <= req_if.dst_reg & iexu_pkg::IDX_MASK;
         src_ff <= req_if.src_reg & iexu_pkg::IDX_MASK;
         imm_ff <= req_if.immediate;
      end
   end

   // ------------------------------------------------------------ register file
   assign rq_dst_wide = 5'(req_if.dst_reg);
   assign rq_src_wide = 5'(req_if.src_reg);
   assign dst_wide    = 5'(dst_ff);
   assign src_wide    = 5'(src_ff);
   assign dst_ok      = dst_wide < 5'(NUM_REGS);
   assign src_ok      = src_wide < 5'(NUM_REGS);

   iexu_regfile #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rq_dst_wide[AW-1:0]),
      .rd_addr_b (rq_src_wide[AW-1:0]),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr_en     (commit && wr_ff),
      .wr_addr   (dst_wide[AW-1:0]),
      .wr_data   (res_ff)
   );

   // Indices beyond the file read as zero.
   assign a = dst_ok ? rf_a : '0;
   assign b = src_ok ? rf_b : '0;

   // ---------------------------------------------------------------- execute
   logic [W-1:0] alu_res, diff;
   logic         alu_wr, alu_taken, alu_derr, is_md, b_zero;
   logic [3:0]   alu_flags;
   logic [5:0]   sh;
   logic [63:0]  a_zx, a_sx, sar64, lea_off;
   iexu_pkg::md_op_type md_op;

   assign sh      = b[5:0] & iexu_pkg::SHIFT_MASK;
   assign a_zx    = 64'(a);
   assign a_sx    = 64'($signed(a));
   assign sar64   = 64'($signed(a_sx) >>> sh);
   assign lea_off = 64'($signed(imm_ff[31:0]));
   assign diff    = a - b;
   assign b_zero  = (b == '0);

   always_comb begin
      alu_res   = '0;
      alu_wr    = 1'b0;
      alu_taken = 1'b0;
      alu_derr  = 1'b0;
      alu_flags = flags_ff;
      is_md     = 1'b0;
      md_op     = iexu_pkg::MD_MUL;
      case (cmd_ff)
         iexu_pkg::CMD_MOV:     begin alu_res = b; alu_wr = 1'b1; end
         iexu_pkg::CMD_MOVIMM:  begin alu_res = imm_ff[W-1:0]; alu_wr = 1'b1; end
         iexu_pkg::CMD_ADD:     begin alu_res = a + b; alu_wr = 1'b1; end
         iexu_pkg::CMD_SUB:     begin alu_res = diff; alu_wr = 1'b1; end
         iexu_pkg::CMD_MUL, iexu_pkg::CMD_SMUL: begin
            alu_wr = 1'b1;
            is_md  = 1'b1;
            md_op  = iexu_pkg::MD_MUL;
         end
         iexu_pkg::CMD_UDIV, iexu_pkg::CMD_SDIV, iexu_pkg::CMD_UMOD: begin
            if (b_zero) begin
               alu_derr = 1'b1;
            end else begin
               alu_wr = 1'b1;
               is_md  = 1'b1;
            end
            if (cmd_ff == iexu_pkg::CMD_UDIV) begin
               md_op = iexu_pkg::MD_UDIV;
            end else if (cmd_ff == iexu_pkg::CMD_SDIV) begin
               md_op = iexu_pkg::MD_SDIV;
            end else begin
               md_op = iexu_pkg::MD_UMOD;
            end
         end
         iexu_pkg::CMD_NEG:     begin alu_res = ~a + 1'b1; alu_wr = 1'b1; end
         iexu_pkg::CMD_AND:     begin alu_res = a & b; alu_wr = 1'b1; end
         iexu_pkg::CMD_OR:      begin alu_res = a | b; alu_wr = 1'b1; end
         iexu_pkg::CMD_XOR:     begin alu_res = a ^ b; alu_wr = 1'b1; end
         iexu_pkg::CMD_NOT:     begin alu_res = ~a; alu_wr = 1'b1; end
         iexu_pkg::CMD_SHL: begin
            alu_res = W'(a_zx << sh);
            alu_wr  = 1'b1;
         end
         iexu_pkg::CMD_SHR: begin
            alu_res = W'(a_zx >> sh);
            alu_wr  = 1'b1;
         end
         iexu_pkg::CMD_SAR: begin
            alu_res = W'(sar64);
            alu_wr  = 1'b1;
         end
         iexu_pkg::CMD_CMP: begin
            alu_flags                    = '0;
            alu_flags[iexu_pkg::FLAG_Z]  = (a == b);
            alu_flags[iexu_pkg::FLAG_SL] = $signed(a) < $signed(b);
            alu_flags[iexu_pkg::FLAG_UL] = a < b;
            alu_flags[iexu_pkg::FLAG_OV] = (a[W-1] ^ b[W-1]) & (a[W-1] ^ diff[W-1]);
         end
         iexu_pkg::CMD_TEST: begin
            alu_flags                   = '0;
            alu_flags[iexu_pkg::FLAG_Z] = ((a & b) == '0);
         end
         iexu_pkg::CMD_JMP: alu_taken = 1'b1;
         iexu_pkg::CMD_JE:  alu_taken = flags_ff[iexu_pkg::FLAG_Z];
         iexu_pkg::CMD_JNE: alu_taken = !flags_ff[iexu_pkg::FLAG_Z];
         iexu_pkg::CMD_JL:  alu_taken = flags_ff[iexu_pkg::FLAG_SL];
         iexu_pkg::CMD_JLE: alu_taken = flags_ff[iexu_pkg::FLAG_SL] | flags_ff[iexu_pkg::FLAG_Z];
         iexu_pkg::CMD_JG:  alu_taken = !(flags_ff[iexu_pkg::FLAG_SL] | flags_ff[iexu_pkg::FLAG_Z]);
         iexu_pkg::CMD_JGE: alu_taken = !flags_ff[iexu_pkg::FLAG_SL];
         iexu_pkg::CMD_LEA: begin
            alu_res = b + lea_off[W-1:0];
            alu_wr  = 1'b1;
         end
         iexu_pkg::CMD_TRUNC8:  begin alu_res = W'(a_zx & iexu_pkg::MASK_8); alu_wr = 1'b1; end
         iexu_pkg::CMD_TRUNC16: begin alu_res = W'(a_zx & iexu_pkg::MASK_16); alu_wr = 1'b1; end
         iexu_pkg::CMD_TRUNC32: begin alu_res = W'(a_zx & iexu_pkg::MASK_32); alu_wr = 1'b1; end
         default: begin
            alu_res = '0;
         end
      endcase
   end

   assign start_md      = (state_ff == iexu_pkg::ST_EXEC) && is_md;
   assign md_ctrl.start = start_md;
   assign md_ctrl.op    = md_op;

   iexu_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .op_a   (a),
      .op_b   (b),
      .done   (md_done),
      .result (md_result)
   );

   always_ff @(posedge clock) begin
      if (state_ff == iexu_pkg::ST_EXEC) begin
         res_ff        <= alu_res;
         wr_ff         <= alu_wr && dst_ok;
         taken_ff      <= alu_taken;
         derr_ff       <= alu_derr;
         flags_pend_ff <= alu_flags;
         target_ff     <= code_base_ff + {32'd0, imm_ff[31:0]};
      end else if ((state_ff == iexu_pkg::ST_MDWAIT) && md_done) begin
         res_ff <= md_result;
      end
   end

   // ----------------------------------------------------------------- commit
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         flags_ff     <= flags_pend_ff;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_result_ff <= wr_ff ? 64'(res_ff) : 64'd0;
         rsp_wr_ff     <= wr_ff;
         rsp_flags_ff  <= flags_pend_ff;
         rsp_taken_ff  <= taken_ff;
         rsp_target_ff <= taken_ff ? target_ff : 64'd0;
         rsp_derr_ff   <= derr_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result_value  = rsp_result_ff;
   assign rsp_if.reg_written   = rsp_wr_ff;
   assign rsp_if.flags_now     = rsp_flags_ff;
   assign rsp_if.branch_taken  = rsp_taken_ff;
   assign rsp_if.branch_target = rsp_target_ff;
   assign rsp_if.div_error     = rsp_derr_ff;

`ifndef SYNTHESIS
   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == iexu_pkg::ST_MDWAIT))
      else $error("multiply/divide unit finished outside its wait state");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == iexu_pkg::ST_EXEC))
      else $error("accepted instruction did not enter execute");

   a_derr_no_write: assert property (@(posedge clock) disable iff (reset)
      (commit && derr_ff) |-> !wr_ff)
      else $error("zero divisor committed a register write");

   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_taken_ff) |-> (rsp_target_ff == 64'd0))
      else $error("branch target set on a branch not taken");
`endif

endmodule

// File: tb/sv/tb_integer_execute_unit_with_flags.sv
// ----------------------------------------------------------------------------
// tb_integer_execute_unit_with_flags: self-checking bench of the execute unit
// Sends directed and random instructions, predicts each outcome from its own
// register file and flags, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_integer_execute_unit_with_flags;
   import iexu_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        written;
      logic [3:0]  flags;
      logic        taken;
      logic [63:0] target;
      logic        derr;
   } outcome_type;

   class exec_scoreboard;
      logic [63:0] regs [8];
      logic [3:0]  flags;
      logic [63:0] base;
      outcome_type pending[$];
      int          errors;

      function void clear();
         foreach (regs[i]) regs[i] = '0;
         flags = '0;
         base = '0;
         errors = 0;
      endfunction

      function void note_instruction(logic [4:0] cmd, logic [2:0] d, logic [2:0] s,
                                     logic [63:0] imm);
         logic [63:0] a, b, res, r, off, ua, ub, q;
         logic        wr, tk, de;
         outcome_type o;
         a = regs[d];
         b = regs[s];
         res = '0; wr = 1'b0; tk = 1'b0; de = 1'b0;
         case (cmd)
            CMD_MOV: begin res = b; wr = 1; end
            CMD_MOVIMM: begin res = imm; wr = 1; end
            CMD_ADD: begin res = a + b; wr = 1; end
            CMD_SUB: begin res = a - b; wr = 1; end
            CMD_MUL, CMD_SMUL: begin res = a * b; wr = 1; end
            CMD_UDIV, CMD_SDIV, CMD_UMOD: begin
               if (b == 0) de = 1;
               else begin
                  wr = 1;
                  if (cmd == CMD_UDIV) res = a / b;
                  else if (cmd == CMD_UMOD) res = a % b;
                  else begin
                     ua = a[63] ? -a : a;
                     ub = b[63] ? -b : b;
                     q = ua / ub;
                     res = (a[63] != b[63]) ? -q : q;
                  end
               end
            end
            CMD_NEG: begin res = -a; wr = 1; end
            CMD_AND: begin res = a & b; wr = 1; end
            CMD_OR: begin res = a | b; wr = 1; end
            CMD_XOR: begin res = a ^ b; wr = 1; end
            CMD_NOT: begin res = ~a; wr = 1; end
            CMD_SHL: begin res = a << b[5:0]; wr = 1; end
            CMD_SHR: begin res = a >> b[5:0]; wr = 1; end
            CMD_SAR: begin res = $signed(a) >>> b[5:0]; wr = 1; end
            CMD_CMP: begin
               r = a - b;
               flags = '0;
               flags[FLAG_Z] = (a == b);
               flags[FLAG_SL] = ($signed(a) < $signed(b));
               flags[FLAG_UL] = (a < b);
               flags[FLAG_OV] = (a[63] ^ b[63]) & (a[63] ^ r[63]);
            end
            CMD_TEST: flags = ((a & b) != 0) ? 4'b0 : 4'b0001;
            CMD_JMP: tk = 1;
            CMD_JE: tk = flags[FLAG_Z];
            CMD_JNE: tk = !flags[FLAG_Z];
            CMD_JL: tk = flags[FLAG_SL];
            CMD_JLE: tk = flags[FLAG_SL] | flags[FLAG_Z];
            CMD_JG: tk = !(flags[FLAG_SL] | flags[FLAG_Z]);
            CMD_JGE: tk = !flags[FLAG_SL];
            CMD_LEA: begin
               off = {{32{imm[31]}}, imm[31:0]};
               res = b + off;
               wr = 1;
            end
            CMD_TRUNC8: begin res = a & MASK_8; wr = 1; end
            CMD_TRUNC16: begin res = a & MASK_16; wr = 1; end
            CMD_TRUNC32: begin res = a & MASK_32; wr = 1; end
            default: ;
         endcase
         if (wr) regs[d] = res;
         else res = '0;
         o.value = res;
         o.written = wr;
         o.flags = flags;
         o.taken = tk;
         o.target = tk ? base + {32'b0, imm[31:0]} : 64'b0;
         o.derr = de;
         pending.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.value, got.value);
            errors++;
         end
         if (got.written !== want.written) begin
            $display("%0t: reg_written expected %b actual %b", $time, want.written, got.written);
            errors++;
         end
         if (got.flags !== want.flags) begin
            $display("%0t: flags_now expected %h actual %h", $time, want.flags, got.flags);
            errors++;
         end
         if (got.taken !== want.taken) begin
            $display("%0t: branch_taken expected %b actual %b", $time, want.taken, got.taken);
            errors++;
         end
         if (got.target !== want.target) begin
            $display("%0t: branch_target expected %h actual %h", $time, want.target,
                     got.target);
            errors++;
         end
         if (got.derr !== want.derr) begin
            $display("%0t: div_error expected %b actual %b", $time, want.derr, got.derr);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [63:0] csr_wdata;
   bit          calm;
   int          quiet_cycles;

   iexu_req_if req_if ();
   iexu_rsp_if rsp_if ();

   exec_scoreboard sb;

   integer_execute_unit_with_flags dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stall bursts, and every transfer goes to the checker.
   initial begin
      int stall;
      outcome_type got;
      rsp_if.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.value = rsp_if.result_value;
            got.written = rsp_if.reg_written;
            got.flags = rsp_if.flags_now;
            got.taken = rsp_if.branch_taken;
            got.target = rsp_if.branch_target;
            got.derr = rsp_if.div_error;
            sb.check_result(got);
         end
         if (stall > 0) stall--;
         else if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 5);
         rsp_if.ready <= (stall == 0);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles > 2000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_instr(cmd_type cmd, logic [2:0] d, logic [2:0] s, logic [63:0] imm);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.dst_reg <= d;
      req_if.src_reg <= s;
      req_if.immediate <= imm;
      do @(posedge clock); while (!req_if.ready);
      sb.note_instruction(cmd, d, s, imm);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_base(logic [63:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.base = value;
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 64'h0;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'hFFFF_FFFF_FFFF_FFFF;
         3: return 64'($urandom_range(0, 70));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_instr();
      cmd_type cmd;
      int pick;
      pick = $urandom_range(0, 99);
      // Keep the slow multiply and divide codes to a modest share.
      if (pick < 15) cmd = cmd_type'($urandom_range(CMD_MUL, CMD_UMOD));
      else if (pick < 30) cmd = CMD_MOVIMM;
      else cmd = cmd_type'($urandom_range(0, 29));
      send_instr(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_value());
   endtask

   initial begin
      sb = new();
      sb.clear();
      calm = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_MOV;
      req_if.dst_reg = '0;
      req_if.src_reg = '0;
      req_if.immediate = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, zero divisor, wrapping signed divide, flags.
      send_instr(CMD_JMP, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_instr(CMD_MOVIMM, 1, 0, 64'h8000_0000_0000_0000);
      send_instr(CMD_MOVIMM, 2, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_instr(CMD_MOV, 3, 1, 0);
      send_instr(CMD_SDIV, 3, 2, 0);
      send_instr(CMD_UDIV, 1, 0, 0);
      send_instr(CMD_UMOD, 2, 0, 0);
      send_instr(CMD_SDIV, 1, 0, 0);
      send_instr(CMD_CMP, 1, 2, 0);
      send_instr(CMD_JL, 0, 0, 64'h8000_0000);
      send_instr(CMD_JLE, 0, 0, 64'h1234);
      send_instr(CMD_JG, 0, 0, 64'h1234);
      send_instr(CMD_JGE, 0, 0, 64'h1234);
      send_instr(CMD_CMP, 2, 2, 0);
      send_instr(CMD_JE, 0, 0, 64'h10);
      send_instr(CMD_JNE, 0, 0, 64'h10);
      send_instr(CMD_TEST, 1, 0, 0);
      send_instr(CMD_LEA, 4, 2, 64'h8000_0000);
      send_instr(CMD_SAR, 1, 2, 0);
      send_instr(CMD_SHL, 2, 2, 0);
      send_instr(CMD_TRUNC8, 2, 0, 0);
      send_instr(CMD_SMUL, 4, 4, 0);
      send_instr(cmd_type'(5'd30), 0, 0, 0);
      send_instr(cmd_type'(5'd31), 7, 7, 64'hFFFF_FFFF_FFFF_FFFF);

      write_base(64'hFFFF_FFFF_FFFF_FFFF);
      repeat (250) random_instr();
      // Let every outstanding result arrive before sending on.
      drain();
      write_base(64'h0);
      repeat (250) random_instr();
      write_base({$urandom, $urandom});
      repeat (150) random_instr();
      calm = 1'b1;
      repeat (150) random_instr();
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
